>>> sv/lrpf_pkg.sv
// Shared types and constants for the page-organized line raster framebuffer.
// Used by lrpf_ctrl, lrpf_dp and the top level; depends on nothing else.
package lrpf_pkg;

    // Request codes carried on the command field.
    typedef enum logic [2:0] {
        CMD_SET_PIXEL = 3'd0,
        CMD_CLR_PIXEL = 3'd1,
        CMD_DRAW_LINE = 3'd2,
        CMD_CLR_STORE = 3'd3,
        CMD_READ_BYTE = 3'd4
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_X_MIN = 3'd0,
        CFG_X_MAX = 3'd1,
        CFG_Y_MIN = 3'd2,
        CFG_Y_MAX = 3'd3
    } t_cfg;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_PLOT_RD,
        ST_PLOT_WR,
        ST_READ,
        ST_DONE
    } t_state;

    // Width of a byte index: the largest page times the widest screen plus a column.
    localparam int IDX_W = 13;

    typedef struct packed {
        logic load;
        logic sweep;
        logic plot_rd;
        logic plot_wr;
        logic rd_issue;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic sweep_last;
        logic walk_brk;
        logic out_free;
    } t_dp_status;

endpackage

>>> sv/line_raster_into_page_framebuffer.sv
// Page-organized monochrome framebuffer with a Bresenham line walker, top level.
// Depends on lrpf_pkg, lrpf_ctrl and lrpf_dp.
//
// Each stored byte holds eight vertical pixels; pixel (x, y) is bit y mod 8 of byte
// (y / 8) * SCREEN_WIDTH + x. One request is worked at a time and each gives one
// reply. The store has a single read and a single write port, so every pixel is a
// read-modify-write in a store read state and a write state; a line walks these
// two states once per pixel on its path, a byte read takes one store read, and a
// store clear writes one byte per cycle. After reset the same clearing pass runs over
// the whole store before the first request is accepted; clip registers can be written
// during it. A finished reply waits in an output register, and the next request is
// accepted once that reply has been loaded.
module line_raster_into_page_framebuffer #(
    parameter int SCREEN_WIDTH = 128,
    parameter int PAGE_COUNT   = 4,
    parameter int STORE_BYTES  = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [6:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_command,
    input  logic [7:0] i_x_start,
    input  logic [7:0] i_y_start,
    input  logic [7:0] i_x_end,
    input  logic [7:0] i_y_end,
    input  logic [8:0] i_read_address,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_read_data
);

    lrpf_pkg::t_dp_cmd    dp_cmd;
    lrpf_pkg::t_dp_status dp_status;

    lrpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_status   (dp_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd)
    );

    lrpf_dp #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .PAGE_COUNT   (PAGE_COUNT),
        .STORE_BYTES  (STORE_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_x_start      (i_x_start),
        .i_y_start      (i_y_start),
        .i_x_end        (i_x_end),
        .i_y_end        (i_y_end),
        .i_read_address (i_read_address),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_read_data    (o_read_data)
    );

endmodule

>>> sv/lrpf_ctrl.sv
// Sequencer for the framebuffer: clearing sweep, pixel and line walks, reads, replies.
// Uses lrpf_pkg; drives the datapath lrpf_dp through t_dp_cmd.
module lrpf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [2:0]          i_command,
    input  lrpf_pkg::t_dp_status i_status,
    output logic                o_in_stall,
    output lrpf_pkg::t_dp_cmd   o_cmd
);

    lrpf_pkg::t_state r_state, n_state;
    logic             r_clr_reply, n_clr_reply;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lrpf_pkg::ST_SWEEP;
            r_clr_reply <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_reply <= n_clr_reply;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_reply = r_clr_reply;
        unique case (r_state)
            lrpf_pkg::ST_SWEEP: begin
                if (i_status.sweep_last) begin
                    n_state     = r_clr_reply ? lrpf_pkg::ST_DONE : lrpf_pkg::ST_IDLE;
                    n_clr_reply = 1'b0;
                end
            end
            lrpf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (lrpf_pkg::t_cmd'(i_command))
                        lrpf_pkg::CMD_SET_PIXEL,
                        lrpf_pkg::CMD_CLR_PIXEL,
                        lrpf_pkg::CMD_DRAW_LINE: n_state = lrpf_pkg::ST_PLOT_RD;
                        lrpf_pkg::CMD_CLR_STORE: begin
                            n_state     = lrpf_pkg::ST_SWEEP;
                            n_clr_reply = 1'b1;
                        end
                        lrpf_pkg::CMD_READ_BYTE: n_state = lrpf_pkg::ST_READ;
                        default:                 n_state = lrpf_pkg::ST_DONE;
                    endcase
                end
            end
            lrpf_pkg::ST_PLOT_RD: n_state = lrpf_pkg::ST_PLOT_WR;
            lrpf_pkg::ST_PLOT_WR: begin
                n_state = i_status.walk_brk ? lrpf_pkg::ST_DONE : lrpf_pkg::ST_PLOT_RD;
            end
            lrpf_pkg::ST_READ: n_state = lrpf_pkg::ST_DONE;
            lrpf_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = lrpf_pkg::ST_IDLE;
                end
            end
            default: n_state = lrpf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_in_stall     = 1'b1;
        unique case (r_state)
            lrpf_pkg::ST_SWEEP:   o_cmd.sweep = 1'b1;
            lrpf_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            lrpf_pkg::ST_PLOT_RD: o_cmd.plot_rd = 1'b1;
            lrpf_pkg::ST_PLOT_WR: o_cmd.plot_wr = 1'b1;
            lrpf_pkg::ST_READ:    o_cmd.rd_issue = 1'b1;
            lrpf_pkg::ST_DONE:    o_cmd.out_load = i_status.out_free;
            default:              o_in_stall = 1'b1;
        endcase
    end

endmodule

>>> sv/lrpf_dp.sv
// Datapath: clip registers, line walker, frame store with read-modify-write, reply register.
// Uses lrpf_pkg; commanded by lrpf_ctrl.
module lrpf_dp #(
    parameter int SCREEN_WIDTH = 128,
    parameter int PAGE_COUNT   = 4,
    parameter int STORE_BYTES  = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lrpf_pkg::t_dp_cmd    i_cmd,
    output lrpf_pkg::t_dp_status o_status,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [6:0]           i_cfg_data,
    input  logic [2:0]           i_command,
    input  logic [7:0]           i_x_start,
    input  logic [7:0]           i_y_start,
    input  logic [7:0]           i_x_end,
    input  logic [7:0]           i_y_end,
    input  logic [8:0]           i_read_address,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [7:0]           o_read_data
);

    localparam int AW = $clog2(STORE_BYTES);

    // Clip window.
    logic [6:0] r_clip_x_min, r_clip_x_max;
    logic [4:0] r_clip_y_min, r_clip_y_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_x_min <= 7'd0;
            r_clip_x_max <= 7'd127;
            r_clip_y_min <= 5'd0;
            r_clip_y_max <= 5'd31;
        end else if (i_cfg_we) begin
            unique case (lrpf_pkg::t_cfg'(i_cfg_index))
                lrpf_pkg::CFG_X_MIN: r_clip_x_min <= i_cfg_data;
                lrpf_pkg::CFG_X_MAX: r_clip_x_max <= i_cfg_data;
                lrpf_pkg::CFG_Y_MIN: r_clip_y_min <= i_cfg_data[4:0];
                lrpf_pkg::CFG_Y_MAX: r_clip_y_max <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Walker state. A single pixel request walks a line whose end is its start.
    logic [7:0]        r_x, r_y, r_xe, r_ye, r_adx, r_ady;
    logic              r_sx_neg, r_sy_neg, r_on, r_is_read, r_rd_ok;
    logic signed [10:0] r_err;
    logic [8:0]        r_rd_addr;

    logic [7:0]        ld_xe, ld_ye, ld_adx, ld_ady;
    logic              is_line;

    always_comb begin
        is_line = lrpf_pkg::t_cmd'(i_command) == lrpf_pkg::CMD_DRAW_LINE;
        ld_xe   = is_line ? i_x_end : i_x_start;
        ld_ye   = is_line ? i_y_end : i_y_start;
        ld_adx  = (i_x_start < ld_xe) ? ld_xe - i_x_start : i_x_start - ld_xe;
        ld_ady  = (i_y_start < ld_ye) ? ld_ye - i_y_start : i_y_start - ld_ye;
    end

    // Bresenham step on the current point.
    logic signed [11:0] e2, ndy, pdx;
    logic               at_end, step_x, step_y, x_stop, x_go, y_go, walk_brk;
    logic signed [10:0] n_err;
    logic [7:0]         n_x, n_y;

    always_comb begin
        e2       = {r_err, 1'b0};
        ndy      = -$signed({4'b0000, r_ady});
        pdx      = $signed({4'b0000, r_adx});
        at_end   = (r_x == r_xe) && (r_y == r_ye);
        step_x   = e2 >= ndy;
        step_y   = e2 <= pdx;
        x_stop   = step_x && (r_x == r_xe);
        x_go     = step_x && !x_stop;
        y_go     = !x_stop && step_y && (r_y != r_ye);
        walk_brk = at_end || x_stop || (step_y && (r_y == r_ye));
        n_err    = r_err - (x_go ? $signed({3'b000, r_ady}) : 11'sd0)
                         + (y_go ? $signed({3'b000, r_adx}) : 11'sd0);
        n_x      = x_go ? (r_sx_neg ? r_x - 8'd1 : r_x + 8'd1) : r_x;
        n_y      = y_go ? (r_sy_neg ? r_y - 8'd1 : r_y + 8'd1) : r_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x   <= 8'd0;
            r_y   <= 8'd0;
            r_err <= 11'sd0;
        end else if (i_cmd.load) begin
            r_x   <= i_x_start;
            r_y   <= i_y_start;
            r_err <= $signed({3'b000, ld_adx}) - $signed({3'b000, ld_ady});
        end else if (i_cmd.plot_wr && !walk_brk) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_err <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xe      <= ld_xe;
            r_ye      <= ld_ye;
            r_adx     <= ld_adx;
            r_ady     <= ld_ady;
            r_sx_neg  <= !(i_x_start < ld_xe);
            r_sy_neg  <= !(i_y_start < ld_ye);
            r_on      <= lrpf_pkg::t_cmd'(i_command) != lrpf_pkg::CMD_CLR_PIXEL;
            r_is_read <= lrpf_pkg::t_cmd'(i_command) == lrpf_pkg::CMD_READ_BYTE;
            r_rd_addr <= i_read_address;
            r_rd_ok   <= 14'(i_read_address) < 14'(STORE_BYTES);
        end
    end

    // Pixel address and write permission.
    logic [4:0]                 page;
    logic [lrpf_pkg::IDX_W-1:0] pix_idx, rd_idx;
    logic                       pix_ok;
    logic [7:0]                 pix_mask, pix_wdata, r_rd_data;

    always_comb begin
        page     = r_y[7:3];
        pix_idx  = lrpf_pkg::IDX_W'(page) * lrpf_pkg::IDX_W'(SCREEN_WIDTH)
                 + lrpf_pkg::IDX_W'(r_x);
        rd_idx   = lrpf_pkg::IDX_W'(r_rd_addr);
        pix_ok   = (r_x >= {1'b0, r_clip_x_min}) && (r_x <= {1'b0, r_clip_x_max})
                && (r_y >= {3'b000, r_clip_y_min}) && (r_y <= {3'b000, r_clip_y_max})
                && ({1'b0, r_x} < 9'(SCREEN_WIDTH))
                && ({1'b0, page} < 6'(PAGE_COUNT))
                && ({1'b0, pix_idx} < 14'(STORE_BYTES));
        pix_mask  = 8'd1 << r_y[2:0];
        pix_wdata = r_on ? (r_rd_data | pix_mask) : (r_rd_data & ~pix_mask);
    end

    // Clearing sweep position; wraps to zero on the last byte.
    logic [AW-1:0] r_clr_idx;
    logic          sweep_last;

    assign sweep_last = r_clr_idx == AW'(STORE_BYTES - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.sweep) begin
            r_clr_idx <= sweep_last ? '0 : r_clr_idx + AW'(1);
        end
    end

    // Frame store: one write port, one registered read port.
    logic [7:0]    r_mem [STORE_BYTES];
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;

    always_comb begin
        mem_we    = i_cmd.sweep || (i_cmd.plot_wr && pix_ok);
        mem_waddr = i_cmd.sweep ? r_clr_idx : pix_idx[AW-1:0];
        mem_wdata = i_cmd.sweep ? 8'd0 : pix_wdata;
        mem_re    = i_cmd.plot_rd || i_cmd.rd_issue;
        mem_raddr = i_cmd.plot_rd ? pix_idx[AW-1:0] : rd_idx[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    // Reply register.
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic       out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= (r_is_read && r_rd_ok) ? r_rd_data : 8'd0;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_read_data         = r_out_data;
    assign o_status.sweep_last = sweep_last;
    assign o_status.walk_brk   = walk_brk;
    assign o_status.out_free   = out_free;

    a_no_sweep_during_plot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.sweep && (i_cmd.plot_wr || i_cmd.plot_rd || i_cmd.rd_issue)))
        else $error("clearing sweep overlaps a store access");

    a_reply_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("reply loaded over a pending reply");

    a_sweep_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sweep && sweep_last) |=> (r_clr_idx == '0))
        else $error("clearing sweep did not return to zero");

    a_walk_stays_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.plot_rd |=> ($stable(r_x) && $stable(r_y)))
        else $error("walker moved between store read and write");

endmodule
